@@ rtl/core/osm_pkg.sv @@
// ----------------------------------------------------------------------------
// osm_pkg
// shared widths, command and status codes, and cell interface types for the
// order statistic multiset unit
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int unsigned VAL_W        = 31;
    localparam int unsigned ACT_W        = 3;
    localparam int unsigned ST_W         = 2;
    localparam int unsigned OSM_CAPACITY = 64;

    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_KTH    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RANK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PRED   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SUCC   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic [VAL_W-1:0] operand;
        logic             ins_en;
        logic             del_en;
    } cell_ctrl_t;

    // per-cell compare results
    typedef struct packed {
        logic lt;
        logic le;
        logic eq;
        logic kmatch;
    } cell_flags_t;

endpackage

@@ rtl/core/osm_cell.sv @@
// ----------------------------------------------------------------------------
// osm_cell
// one slot of the sorted chain: holds a value and an occupied bit, compares
// against the broadcast operand and shifts toward either neighbor
// ----------------------------------------------------------------------------
module osm_cell
    import osm_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [VAL_W-1:0]  left_val,
    input  logic              left_occ,
    input  logic              left_le,
    input  logic [VAL_W-1:0]  right_val,
    input  logic              right_occ,
    output logic [VAL_W-1:0]  val,
    output logic              occ,
    output cell_flags_t       flags
);

    logic [VAL_W-1:0] val_reg;
    logic             occ_reg;

    assign flags.lt     = occ_reg && (val_reg < ctrl.operand);
    assign flags.le     = occ_reg && (val_reg <= ctrl.operand);
    assign flags.eq     = occ_reg && (val_reg == ctrl.operand);
    assign flags.kmatch = occ_reg && (ctrl.operand == VAL_W'(IDX + 1));

    // insert: cells above the operand move up one slot, the first one takes it
    // delete: cells from the removed copy on take their right neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else if (ctrl.ins_en && !flags.le) begin
            occ_reg <= left_le ? 1'b1 : left_occ;
        end else if (ctrl.del_en && !flags.lt) begin
            occ_reg <= right_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ins_en && !flags.le) begin
            val_reg <= left_le ? ctrl.operand : left_val;
        end else if (ctrl.del_en && !flags.lt) begin
            val_reg <= right_val;
        end
    end

    assign val = val_reg;
    assign occ = occ_reg;

endmodule

@@ rtl/core/osm_select.sv @@
// ----------------------------------------------------------------------------
// osm_select
// turns a one-hot cell select into the stored value or, for rank, into the
// cell index
// ----------------------------------------------------------------------------
module osm_select
    import osm_pkg::*;
#(
    parameter int unsigned CAPACITY = OSM_CAPACITY
) (
    input  logic [CAPACITY-1:0]            sel,
    input  logic                           all_below,
    input  logic                           is_rank,
    input  logic [CAPACITY-1:0][VAL_W-1:0] values,
    output logic [VAL_W-1:0]               result
);

    localparam int unsigned IW = $clog2(CAPACITY + 1);

    logic [VAL_W-1:0] vsel;
    logic [IW-1:0]    idx;

    always_comb begin
        vsel = '0;
        idx  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (sel[i]) begin
                vsel = vsel | values[i];
                idx  = idx | IW'(i);
            end
        end
        if (all_below) begin
            idx = IW'(CAPACITY);
        end
    end

    assign result = is_rank ? VAL_W'(idx) : vsel;

endmodule

@@ rtl/core/order_statistic_multiset_unit.sv @@
// ----------------------------------------------------------------------------
// order_statistic_multiset_unit
// sorted multiset of 31-bit values with insert, delete, kth, rank,
// predecessor and successor commands
// ----------------------------------------------------------------------------
// Values live in a chain of CAPACITY cells kept in ascending order; every cell
// compares itself with the command operand in the same cycle, and an insert or
// delete moves the affected cells one slot toward a neighbor at once. A request
// is latched at its acceptance edge; in the execute step the cells compare
// and shift and the answering cell is registered as a select, and in the
// select step that cell is picked out of the chain into the output register.
// A new request is taken in the cycle after the previous result is loaded
// into the output register, so requests do not overlap; a stalled result
// holds the input off. The store is empty after reset with no clearing pass.
// Status 0 is ok, 1 not found or out of range, 2 store full; result_value is
// zero unless status is ok and the command is a query.
// ----------------------------------------------------------------------------
module order_statistic_multiset_unit
    import osm_pkg::*;
#(
    parameter int unsigned CAPACITY = OSM_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] operand
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] result_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [ACT_W-1:0] act_reg;
    logic [VAL_W-1:0] op_reg;

    logic [CAPACITY-1:0] sel_reg, sel_next;
    logic                all_reg, all_next;
    logic                rank_reg, rank_next;
    logic [ST_W-1:0]     stat_reg, stat_next;

    logic             m_tvalid_reg;
    logic [VAL_W-1:0] m_res_reg;
    logic [ST_W-1:0]  m_stat_reg;

    cell_ctrl_t                     ctrl;
    cell_flags_t [CAPACITY-1:0]     flags_w;
    logic [CAPACITY-1:0][VAL_W-1:0] vals;
    logic [CAPACITY-1:0]            occ;
    logic [CAPACITY-1:0]            lt, le, eq, km;
    logic [CAPACITY-1:0]            bl, pr, sc, dl;
    logic                           full, found;
    logic [VAL_W-1:0]               sel_result;
    logic                           out_free;

    assign full     = occ[CAPACITY-1];
    assign found    = |dl;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ctrl.operand = op_reg;
    assign ctrl.ins_en  = (state_reg == S_EXEC) && (act_reg == ACT_INSERT) && !full;
    assign ctrl.del_en  = (state_reg == S_EXEC) && (act_reg == ACT_DELETE) && found;

    // chain of cells with neighbor wiring
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VAL_W-1:0] lv, rv;
        logic             lo, ro, lle;

        if (i == 0) begin : g_left_end
            assign lv  = '0;
            assign lo  = 1'b0;
            assign lle = 1'b1;
            assign bl[i] = !lt[i];
            assign sc[i] = occ[i] && !le[i];
            assign dl[i] = eq[i];
        end else begin : g_left
            assign lv  = vals[i-1];
            assign lo  = occ[i-1];
            assign lle = le[i-1];
            assign bl[i] = !lt[i] && lt[i-1];
            assign sc[i] = occ[i] && !le[i] && le[i-1];
            assign dl[i] = eq[i] && lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_right_end
            assign rv    = '0;
            assign ro    = 1'b0;
            assign pr[i] = lt[i];
        end else begin : g_right
            assign rv    = vals[i+1];
            assign ro    = occ[i+1];
            assign pr[i] = lt[i] && !lt[i+1];
        end

        osm_cell #(
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .left_val  (lv),
            .left_occ  (lo),
            .left_le   (lle),
            .right_val (rv),
            .right_occ (ro),
            .val       (vals[i]),
            .occ       (occ[i]),
            .flags     (flags_w[i])
        );

        assign lt[i] = flags_w[i].lt;
        assign le[i] = flags_w[i].le;
        assign eq[i] = flags_w[i].eq;
        assign km[i] = flags_w[i].kmatch;
    end

    // pick the answering cell
    always_comb begin
        sel_next  = '0;
        all_next  = 1'b0;
        rank_next = 1'b0;
        stat_next = ST_OK;
        case (act_reg)
            ACT_INSERT: begin
                stat_next = full ? ST_FULL : ST_OK;
            end
            ACT_DELETE: begin
                stat_next = found ? ST_OK : ST_NOTFOUND;
            end
            ACT_KTH: begin
                sel_next  = km;
                stat_next = (|km) ? ST_OK : ST_NOTFOUND;
            end
            ACT_RANK: begin
                sel_next  = bl;
                all_next  = lt[CAPACITY-1];
                rank_next = 1'b1;
            end
            ACT_PRED: begin
                sel_next  = pr;
                stat_next = (|pr) ? ST_OK : ST_NOTFOUND;
            end
            ACT_SUCC: begin
                sel_next  = sc;
                stat_next = (|sc) ? ST_OK : ST_NOTFOUND;
            end
            default: begin
                stat_next = ST_NOTFOUND;
            end
        endcase
    end

    osm_select #(
        .CAPACITY (CAPACITY)
    ) u_select (
        .sel       (sel_reg),
        .all_below (all_reg),
        .is_rank   (rank_reg),
        .values    (vals),
        .result    (sel_result)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_SEL;
            end
            S_SEL: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= s_tuser[ACT_W-1:0];
            op_reg  <= s_tdata[VAL_W-1:0];
        end
        if (state_reg == S_EXEC) begin
            sel_reg  <= sel_next;
            all_reg  <= all_next;
            rank_reg <= rank_next;
            stat_reg <= stat_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_SEL && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_SEL && out_free) begin
            m_res_reg  <= (stat_reg == ST_OK) ? sel_result : '0;
            m_stat_reg <= stat_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg};
    assign m_tuser  = m_stat_reg;

    // occupied cells always form a prefix of the chain
    a_occ_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ >> 1) & ~occ) == '0)
        else $error("occupied cells not contiguous");

    // at most one cell answers a query
    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SEL |-> $onehot0(sel_reg))
        else $error("more than one cell selected");

    // queries leave the set of occupied cells unchanged
    a_query_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EXEC && act_reg != ACT_INSERT && act_reg != ACT_DELETE
        |=> $stable(occ))
        else $error("query changed the store");

    // a new result is loaded only from the select step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_SEL))
        else $error("result loaded outside select step");

    // failed or full requests carry a zero value
    a_zero_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_stat_reg != ST_OK |-> m_res_reg == '0)
        else $error("nonzero value with error status");

endmodule
